@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cfd_pkg.sv @@
package cfd_pkg;

  // Storage geometry.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_DEDUP = 2'd2,
    CMD_DUMP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                     command;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] read_value;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;
  } rsp_t;

  // Write port of the word store.
  typedef struct packed {
    logic  en;
    idx_t  addr;
    data_t data;
  } ram_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_DD_RD,
    S_DD_LOAD,
    S_DD_CRD,
    S_DD_CCHK,
    S_DD_KEEP,
    S_DD_NEXT,
    S_DD_DONE
  } state_t;

  // Circular index arithmetic: base plus an offset of at most DEPTH, wrapped once.
  function automatic idx_t ptr_add(idx_t base, cnt_t offs);
    sum_t s;
    s = sum_t'(base) + sum_t'(offs);
    if (s >= sum_t'(DEPTH)) begin
      s = s - sum_t'(DEPTH);
    end
    return idx_t'(s);
  endfunction

endpackage

@@ rtl/circular_fifo_with_dedup.sv @@
// Circular FIFO of signed 32-bit words with push, pop, duplicate removal and dump.
// Commands arrive on the req channel (valid/stall); results leave on the rsp
// channel (valid/stall). Every command gives one result with last set, except a
// dump of a non-empty FIFO, which gives one result per stored word, oldest first,
// with last set only on the final one.
// One command is worked on at a time; req_stall is high until its final result
// has been loaded into the output register.
// Push and pop capture the command while the head word is read from the store, and
// then update the pointers and load the result once the output register is free.
// Dump reads each stored word (registered read port) and then loads it as a result.
// Dedup runs on one shared 32-bit comparator: each stored word is read, made the
// candidate, compared with the kept words and kept if none match; then one result.
// Reset clears the pointers, the count and the output valid; the store itself
// is not cleared and needs no clearing pass.
// While the receiver holds rsp_stall, the pending result stays in place and the
// sequencer waits before loading the next one; no result is lost or repeated.
module circular_fifo_with_dedup import cfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t  state, state_next;
  cmd_t    cmd_r;
  data_t   val_r;
  idx_t    head, tail;
  cnt_t    count;
  cnt_t    scan, kept, cmp;
  data_t   cand;
  idx_t    rd_addr;
  data_t   rd_data;
  ram_wr_t wr;
  logic    emit;
  rsp_t    emit_data;
  logic    rsp_free;
  logic    full, empty, match;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign full      = (count == cnt_t'(DEPTH));
  assign empty     = (count == '0);
  assign match     = (rd_data == cand);
  assign req_stall = (state != S_IDLE);

  cfd_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_DEDUP: begin
            if (!empty) state_next = S_DD_RD;
            else if (rsp_free) state_next = S_IDLE;
          end
          CMD_DUMP: begin
            if (!empty) state_next = S_DUMP_RD;
            else if (rsp_free) state_next = S_IDLE;
          end
          default: begin
            if (rsp_free) state_next = S_IDLE;
          end
        endcase
      end
      S_DUMP_RD:  state_next = S_DUMP_OUT;
      S_DUMP_OUT: begin
        if (rsp_free) begin
          state_next = (scan == count - 1'b1) ? S_IDLE : S_DUMP_RD;
        end
      end
      S_DD_RD:   state_next = S_DD_LOAD;
      S_DD_LOAD: state_next = (kept == '0) ? S_DD_KEEP : S_DD_CRD;
      S_DD_CRD:  state_next = S_DD_CCHK;
      S_DD_CCHK: begin
        if (match) state_next = S_DD_NEXT;
        else if (cmp == kept - 1'b1) state_next = S_DD_KEEP;
        else state_next = S_DD_CRD;
      end
      S_DD_KEEP: state_next = S_DD_NEXT;
      S_DD_NEXT: state_next = (scan == count - 1'b1) ? S_DD_DONE : S_DD_RD;
      S_DD_DONE: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: store read address, store write, result load.
  always_comb begin
    rd_addr              = head;
    wr                   = '0;
    emit                 = 1'b0;
    emit_data            = '0;
    emit_data.status     = ST_OK;
    emit_data.occupancy  = OCC_W'(count);
    emit_data.last       = 1'b1;
    case (state)
      S_EXEC: begin
        case (cmd_r)
          CMD_PUSH: begin
            emit = rsp_free;
            if (full) begin
              emit_data.status = ST_OVERFLOW;
            end else begin
              emit_data.occupancy = OCC_W'(count + 1'b1);
              wr.en   = rsp_free;
              wr.addr = tail;
              wr.data = val_r;
            end
          end
          CMD_POP: begin
            emit = rsp_free;
            if (empty) begin
              emit_data.status = ST_EMPTY;
            end else begin
              emit_data.read_value = rd_data;
              emit_data.occupancy  = OCC_W'(count - 1'b1);
            end
          end
          default: begin
            emit             = rsp_free && empty;
            emit_data.status = ST_EMPTY;
          end
        endcase
      end
      S_DUMP_RD, S_DUMP_OUT: begin
        rd_addr = ptr_add(head, scan);
        if (state == S_DUMP_OUT) begin
          emit                 = rsp_free;
          emit_data.read_value = rd_data;
          emit_data.last       = (scan == count - 1'b1);
        end
      end
      S_DD_RD, S_DD_LOAD, S_DD_NEXT: begin
        rd_addr = ptr_add(head, scan);
      end
      S_DD_CRD, S_DD_CCHK: begin
        rd_addr = ptr_add(head, cmp);
      end
      S_DD_KEEP: begin
        wr.en   = 1'b1;
        wr.addr = ptr_add(head, kept);
        wr.data = cand;
      end
      S_DD_DONE: begin
        emit                = rsp_free;
        emit_data.occupancy = OCC_W'(kept);
      end
      default: begin
        rd_addr = head;
      end
    endcase
  end

  // Control registers: sequencer state, pointers, count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (state == S_EXEC && rsp_free) begin
        if (cmd_r == CMD_PUSH && !full) begin
          tail  <= ptr_add(tail, cnt_t'(1));
          count <= count + 1'b1;
        end
        if (cmd_r == CMD_POP && !empty) begin
          head  <= ptr_add(head, cnt_t'(1));
          count <= count - 1'b1;
        end
      end
      if (state == S_DD_DONE && rsp_free) begin
        count <= kept;
        tail  <= ptr_add(head, kept);
      end
    end
  end

  // Payload registers: captured command, walk counters, candidate word, result.
  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= emit_data;
    end
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd_r <= req.command;
          val_r <= req.push_value;
          scan  <= '0;
          kept  <= '0;
        end
      end
      S_DUMP_OUT: begin
        if (rsp_free) scan <= scan + 1'b1;
      end
      S_DD_LOAD: begin
        cand <= rd_data;
        cmp  <= '0;
      end
      S_DD_CCHK: begin
        if (!match) cmp <= cmp + 1'b1;
      end
      S_DD_KEEP: kept <= kept + 1'b1;
      S_DD_NEXT: scan <= scan + 1'b1;
      default: begin
        cand <= cand;
      end
    endcase
  end

endmodule

@@ rtl/cfd_ram.sv @@
module cfd_ram import cfd_pkg::*; (
  input  logic    clk,
  input  ram_wr_t wr,
  input  idx_t    rd_addr,
  output data_t   rd_data
);

  data_t mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/cfd_chk.sv @@
`include "assert_macros.svh"

module cfd_chk import cfd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  logic ovf_seen, ovf_ok, empty_seen, empty_ok;

  assign ovf_seen   = rsp_valid && rsp.status == ST_OVERFLOW;
  assign ovf_ok     = (rsp.occupancy == OCC_W'(DEPTH)) && rsp.last;
  assign empty_seen = rsp_valid && rsp.status == ST_EMPTY;
  assign empty_ok   = (rsp.occupancy == '0) && rsp.last && (rsp.read_value == '0);

  // An overflow is only reported with every slot taken.
  `ASSERT_IMP(a_ovf_full, ovf_seen, ovf_ok, "overflow reported while not full")

  // An empty status is always a lone final result on an empty FIFO.
  `ASSERT_IMP(a_empty_zero, empty_seen, empty_ok, "empty status with stored words")

  // Occupancy never goes past the number of slots.
  `ASSERT_IMP(a_occ_range, rsp_valid, rsp.occupancy <= DEPTH, "occupancy beyond depth")

  // A transfer on the request side blocks further commands in the next cycle.
  `ASSERT_NEXT(a_one_cmd, req_valid && !req_stall, req_stall, "second command while busy")

endmodule

bind circular_fifo_with_dedup cfd_chk u_cfd_chk (.*);

@@ dv/circular_fifo_with_dedup_test.sv @@
`timescale 1ns / 1ps

module circular_fifo_with_dedup_test;
  import cfd_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 400;

  // Mirror of the FIFO contents and the queue of results still owed by the block.
  class cfd_scoreboard;
    data_t       words [DEPTH];
    int unsigned head_slot;
    int unsigned tail_slot;
    int unsigned word_count;
    rsp_t        awaited_rsps [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned overflow_count;
    int unsigned empty_count;
    int unsigned cmd_count [4];

    // Applies one accepted command to the mirror and queues the results it owes.
    function void note_command(req_t cmd);
      rsp_t        outcome;
      data_t       kept [$];
      int unsigned slot;
      bit          seen;
      cmd_count[int'(cmd.command)]++;
      outcome = '0;
      outcome.last = 1'b1;
      if (cmd.command != CMD_PUSH && word_count == 0) begin
        outcome.status = ST_EMPTY;
        empty_count++;
      end else begin
        case (cmd.command)
          CMD_PUSH: begin
            if (word_count >= DEPTH) begin
              outcome.status = ST_OVERFLOW;
              overflow_count++;
            end else begin
              words[tail_slot] = cmd.push_value;
              tail_slot = (tail_slot + 1) % DEPTH;
              word_count++;
              outcome.status = ST_OK;
            end
          end
          CMD_POP: begin
            outcome.status = ST_OK;
            outcome.read_value = words[head_slot];
            head_slot = (head_slot + 1) % DEPTH;
            word_count--;
          end
          CMD_DEDUP: begin
            // Keep the first copy of each value and repack from the head.
            slot = head_slot;
            for (int n = 0; n < word_count; n++) begin
              seen = 1'b0;
              foreach (kept[j]) begin
                if (kept[j] == words[slot]) seen = 1'b1;
              end
              if (!seen) kept.push_back(words[slot]);
              slot = (slot + 1) % DEPTH;
            end
            slot = head_slot;
            foreach (kept[j]) begin
              words[slot] = kept[j];
              slot = (slot + 1) % DEPTH;
            end
            word_count = kept.size();
            tail_slot = slot;
            outcome.status = ST_OK;
          end
          default: begin
            // A dump returns every stored word, oldest first, and changes nothing.
            slot = head_slot;
            for (int n = 0; n < word_count; n++) begin
              outcome.status = ST_OK;
              outcome.read_value = words[slot];
              outcome.occupancy = word_count[OCC_W-1:0];
              outcome.last = (n + 1 == word_count);
              awaited_rsps.push_back(outcome);
              slot = (slot + 1) % DEPTH;
            end
            return;
          end
        endcase
      end
      outcome.occupancy = word_count[OCC_W-1:0];
      awaited_rsps.push_back(outcome);
    endfunction

    // Compares one result transfer with the oldest owed result.
    function void check_result(rsp_t got);
      rsp_t want;
      results_seen++;
      if (awaited_rsps.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: status %0d value %0d occupancy %0d last %0b",
                 $time, got.status, $signed(got.read_value), got.occupancy, got.last);
        return;
      end
      want = awaited_rsps.pop_front();
      if (got.status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
      end
      if (got.read_value !== want.read_value) begin
        mismatches++;
        $display("%0t: read_value mismatch: expected %0d, actual %0d",
                 $time, $signed(want.read_value), $signed(got.read_value));
      end
      if (got.occupancy !== want.occupancy) begin
        mismatches++;
        $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                 $time, want.occupancy, got.occupancy);
      end
      if (got.last !== want.last) begin
        mismatches++;
        $display("%0t: last mismatch: expected %0b, actual %0b",
                 $time, want.last, got.last);
      end
    endfunction

    function int unsigned pending();
      return awaited_rsps.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  cfd_scoreboard sb;
  int unsigned   cycle_count = 0;
  int unsigned   hold_requests = 0;
  int unsigned   hold_stretches = 0;

  circular_fifo_with_dedup uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
      $display("circular_fifo_with_dedup_test failed");
      $finish;
    end
  end

  // Command transfers feed the mirror; result transfers are checked against it.
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.note_command(req);
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  // Sends one command after an idle gap, starting and ending at a falling edge.
  task automatic send_cmd(input req_t item, input int unsigned gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: a random stall before each transfer, quiet stretches, and a
  // long hold when asked for.
  initial begin
    int unsigned stall_len;
    int unsigned taken;
    taken = 0;
    rsp_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_stretches < hold_requests) begin
        stall_len = HOLD_CYCLES;
        hold_stretches++;
      end else if ((taken / 40) % 4 == 2) begin
        stall_len = 0;
      end else begin
        stall_len = $urandom_range(0, 14);
      end
      if (stall_len > 0) begin
        rsp_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    req_t        directed [$];
    req_t        item;
    int unsigned pick;
    int unsigned phase;
    int unsigned gap;

    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: every command on an empty FIFO, word extremes, duplicates,
    // dedup with and without duplicates, and popping back down to empty.
    directed.push_back('{command: CMD_POP,   push_value: 0});
    directed.push_back('{command: CMD_DUMP,  push_value: 0});
    directed.push_back('{command: CMD_DEDUP, push_value: 0});
    directed.push_back('{command: CMD_PUSH,  push_value: 32'sh8000_0000});
    directed.push_back('{command: CMD_PUSH,  push_value: 32'sh7fff_ffff});
    directed.push_back('{command: CMD_PUSH,  push_value: 32'sh8000_0000});
    directed.push_back('{command: CMD_PUSH,  push_value: 0});
    directed.push_back('{command: CMD_PUSH,  push_value: -1});
    directed.push_back('{command: CMD_PUSH,  push_value: 32'sh7fff_ffff});
    directed.push_back('{command: CMD_PUSH,  push_value: -1});
    directed.push_back('{command: CMD_DUMP,  push_value: 0});
    directed.push_back('{command: CMD_DEDUP, push_value: 0});
    directed.push_back('{command: CMD_DUMP,  push_value: 0});
    directed.push_back('{command: CMD_POP,   push_value: 0});
    directed.push_back('{command: CMD_POP,   push_value: 0});
    directed.push_back('{command: CMD_DEDUP, push_value: 0});
    directed.push_back('{command: CMD_POP,   push_value: 0});
    directed.push_back('{command: CMD_POP,   push_value: 0});
    directed.push_back('{command: CMD_POP,   push_value: 0});
    directed.push_back('{command: CMD_DUMP,  push_value: 0});
    foreach (directed[k]) send_cmd(directed[k], $urandom_range(0, 14));

    // Random part in phases: filling, mixed and draining, so the FIFO runs
    // full, wraps its pointers and runs empty again many times.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      phase = (i / 40) % 3;
      pick = $urandom_range(0, 99);
      case (phase)
        0: item.command = (pick < 70) ? CMD_PUSH : (pick < 80) ? CMD_POP :
                          (pick < 90) ? CMD_DEDUP : CMD_DUMP;
        1: item.command = (pick < 40) ? CMD_PUSH : (pick < 75) ? CMD_POP :
                          (pick < 87) ? CMD_DEDUP : CMD_DUMP;
        default: item.command = (pick < 20) ? CMD_PUSH : (pick < 80) ? CMD_POP :
                                (pick < 90) ? CMD_DEDUP : CMD_DUMP;
      endcase

      // Mostly a small pool of values so that dedup has work to do.
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        item.push_value = data_t'(int'($urandom_range(0, 5)) - 3);
      end else if (pick < 65) begin
        case ($urandom_range(0, 3))
          0: item.push_value = 32'sh8000_0000;
          1: item.push_value = 32'sh7fff_ffff;
          2: item.push_value = -1;
          default: item.push_value = 0;
        endcase
      end else begin
        item.push_value = $urandom();
      end

      // The result side holds off for a long stretch while commands keep coming.
      if (i == 120) hold_requests++;

      // Let every owed result drain before going on.
      if (i == 260) begin
        req_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        @(negedge clk);
      end

      gap = ((i / 30) % 4 == 3) ? 0 : $urandom_range(0, 14);
      send_cmd(item, gap);
    end
    req_valid <= 1'b0;

    do @(negedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Commands: %0d push, %0d pop, %0d dedup, %0d dump; %0d results compared.",
             sb.cmd_count[CMD_PUSH], sb.cmd_count[CMD_POP], sb.cmd_count[CMD_DEDUP],
             sb.cmd_count[CMD_DUMP], sb.results_seen);
    $display("Overflows %0d, empty results %0d, long result holds %0d, mismatches %0d.",
             sb.overflow_count, sb.empty_count, hold_stretches, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("circular_fifo_with_dedup_test passed");
    end else begin
      $display("circular_fifo_with_dedup_test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cfd_pkg.sv
rtl/cfd_ram.sv
rtl/circular_fifo_with_dedup.sv
rtl/cfd_chk.sv
dv/circular_fifo_with_dedup_test.sv
